[rtl/iqws_pkg.sv]
// ----------------------------------------------------------------------------
// iqws_pkg
// Shared types and constants of the issue queue with wakeup and select.
// ----------------------------------------------------------------------------
package iqws_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ISSUE_MAX_DEF   = 4;
	localparam int TAG_BITS_DEF    = 8;
	localparam int XLEN_DEF        = 32;

	localparam int CFG_W        = 1;
	localparam int IW_W         = 3;
	localparam int QL_W         = 5;
	localparam int SEQ_W        = 8;
	localparam int OUT_VAL_W    = 32;
	localparam int KIND_W       = 3;

	typedef enum logic [1:0] {
		MODE_DISPATCH = 2'd0,
		MODE_COMPLETE = 2'd1,
		MODE_ISSUE    = 2'd2,
		MODE_FLUSH    = 2'd3
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPTED = 3'd0,
		KIND_FULL     = 3'd1,
		KIND_ISSUED   = 3'd2,
		KIND_NONE     = 3'd3,
		KIND_DONE     = 3'd4,
		KIND_FLUSHED  = 3'd5
	} kind_t;

	localparam logic [CFG_W-1:0] REG_ISSUE_WIDTH = 1'd0;
	localparam logic [CFG_W-1:0] REG_QUEUE_LIMIT = 1'd1;

	// control that all cells see in the same cycle
	typedef struct packed {
		logic wake;    // broadcast of a completion that writes a destination
		logic shift;   // compaction step: each cell at or above the gap takes its upper neighbor
		logic load;    // dispatch write at the tail
	} cell_ctl_t;

endpackage

[rtl/iqws_cell.sv]
// ----------------------------------------------------------------------------
// iqws_cell
// One queue slot: holds an instruction, snoops completion tags and takes
// the contents of its upper neighbor on a compaction step.
// ----------------------------------------------------------------------------
module iqws_cell
	import iqws_pkg::*;
#(
	parameter int TAG_BITS = TAG_BITS_DEF,
	parameter int XLEN     = XLEN_DEF
) (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic                sel_load,
	input  logic                sel_shift,
	input  logic [TAG_BITS-1:0] wake_tag,
	input  logic [XLEN-1:0]     wake_value,
	input  logic [TAG_BITS-1:0] in_seq,
	input  logic [TAG_BITS-1:0] in_tag_a,
	input  logic                in_rdy_a,
	input  logic [XLEN-1:0]     in_val_a,
	input  logic [TAG_BITS-1:0] in_tag_b,
	input  logic                in_rdy_b,
	input  logic [XLEN-1:0]     in_val_b,
	input  logic                in_mem,
	input  logic [TAG_BITS-1:0] nb_seq,
	input  logic [TAG_BITS-1:0] nb_tag_a,
	input  logic                nb_rdy_a,
	input  logic [XLEN-1:0]     nb_val_a,
	input  logic [TAG_BITS-1:0] nb_tag_b,
	input  logic                nb_rdy_b,
	input  logic [XLEN-1:0]     nb_val_b,
	input  logic                nb_mem,
	output logic [TAG_BITS-1:0] seq_q,
	output logic [TAG_BITS-1:0] tag_a_q,
	output logic                rdy_a_q,
	output logic [XLEN-1:0]     val_a_q,
	output logic [TAG_BITS-1:0] tag_b_q,
	output logic                rdy_b_q,
	output logic [XLEN-1:0]     val_b_q,
	output logic                mem_q
);

	always_ff @(posedge clk) begin
		if (ctl.load && sel_load) begin
			seq_q   <= in_seq;
			tag_a_q <= in_tag_a;
			rdy_a_q <= in_rdy_a;
			val_a_q <= in_val_a;
			tag_b_q <= in_tag_b;
			rdy_b_q <= in_rdy_b;
			val_b_q <= in_val_b;
			mem_q   <= in_mem;
		end else if (ctl.shift && sel_shift) begin
			seq_q   <= nb_seq;
			tag_a_q <= nb_tag_a;
			rdy_a_q <= nb_rdy_a;
			val_a_q <= nb_val_a;
			tag_b_q <= nb_tag_b;
			rdy_b_q <= nb_rdy_b;
			val_b_q <= nb_val_b;
			mem_q   <= nb_mem;
		end else if (ctl.wake) begin
			if (!rdy_a_q && tag_a_q == wake_tag) begin
				rdy_a_q <= 1'b1;
				val_a_q <= wake_value;
			end
			if (!rdy_b_q && tag_b_q == wake_tag) begin
				rdy_b_q <= 1'b1;
				val_b_q <= wake_value;
			end
		end
	end

endmodule

[rtl/issue_queue_wakeup_select.sv]
// ----------------------------------------------------------------------------
// issue_queue_wakeup_select
// Age-ordered issue queue built as a row of cells with a completion board.
// ----------------------------------------------------------------------------
// Result path after the input transfer: dispatch passes board read, cell
// write and output register; completion, flush and refused dispatch skip the cell write.
// Issue tick: a decode step, a scan step per skipped entry, and per issued
// entry scan, pack, output and transfer; a none-ready answer adds output and transfer.
// Items are taken one at a time, the next one the cycle after the last transfer.
// Reset: registers to defaults, queue empty, board cleared, input stalled while the board clears.
// ----------------------------------------------------------------------------
module issue_queue_wakeup_select
	import iqws_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ISSUE_MAX   = ISSUE_MAX_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF,
	parameter int XLEN        = XLEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_index,
	input  logic [QL_W-1:0]      cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [TAG_BITS-1:0]  seq,
	input  logic [TAG_BITS-1:0]  src1_tag,
	input  logic                 src1_ready,
	input  logic [XLEN-1:0]      src1_value,
	input  logic [TAG_BITS-1:0]  src2_tag,
	input  logic                 src2_ready,
	input  logic [XLEN-1:0]      src2_value,
	input  logic                 is_memory,
	input  logic                 writes_dest,
	input  logic [XLEN-1:0]      done_value,
	input  logic [TAG_BITS-1:0]  mem_limit,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [KIND_W-1:0]    kind,
	output logic [TAG_BITS-1:0]  out_seq,
	output logic [XLEN-1:0]      out_src1,
	output logic [XLEN-1:0]      out_src2,
	output logic                 last
);

	localparam int QI_W  = $clog2(QUEUE_DEPTH);
	localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int IC_W  = $clog2(ISSUE_MAX + 1);
	localparam int SLOTS = 1 << TAG_BITS;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_RD    = 7'b0000100,
		ST_DISP  = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_PACK  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [IW_W-1:0] width_cfg_q;
	logic [QL_W-1:0] queue_limit_q;

	// latched item
	logic [1:0]          mode_q;
	logic [TAG_BITS-1:0] seq_q, tag1_q, tag2_q, lim_q;
	logic                rdy1_q, rdy2_q, mem_in_q, wr_q;
	logic [XLEN-1:0]     val1_q, val2_q, dval_q;

	// completion board
	logic [SLOTS-1:0]    bvalid_q;
	logic [XLEN-1:0]     bres_mem [SLOTS];
	logic [XLEN-1:0]     bres1_q, bres2_q;
	logic                bhit1_q, bhit2_q;

	logic [QC_W-1:0] count_q;
	logic [QC_W-1:0] ptr_q;
	logic [IC_W-1:0] nissue_q;
	logic [QI_W-1:0] gap_q;

	// row of cells
	logic [TAG_BITS-1:0] c_seq [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] c_ta  [QUEUE_DEPTH];
	logic                c_ra  [QUEUE_DEPTH];
	logic [XLEN-1:0]     c_va  [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] c_tb  [QUEUE_DEPTH];
	logic                c_rb  [QUEUE_DEPTH];
	logic [XLEN-1:0]     c_vb  [QUEUE_DEPTH];
	logic                c_mem [QUEUE_DEPTH];

	cell_ctl_t ctl;

	logic [QI_W-1:0] ptr_idx;
	logic            cand_ok;
	logic [IC_W-1:0] width_eff;
	logic [QC_W-1:0] limit_eff;
	logic            in_acc;
	logic            scan_end;
	logic            more_after;
	logic            last_issue;

	assign ptr_idx   = ptr_q[QI_W-1:0];
	assign width_eff = (IC_W'(width_cfg_q) > IC_W'(ISSUE_MAX)) ? IC_W'(ISSUE_MAX)
		: IC_W'(width_cfg_q);
	assign limit_eff = (32'(queue_limit_q) > 32'(QUEUE_DEPTH)) ? QC_W'(QUEUE_DEPTH)
		: QC_W'(queue_limit_q);
	assign cand_ok   = c_ra[ptr_idx] && c_rb[ptr_idx]
		&& !(c_mem[ptr_idx] && c_seq[ptr_idx] > lim_q);
	assign scan_end  = (ptr_q >= count_q) || (nissue_q >= width_eff);
	assign last_issue = (IC_W'(nissue_q + 1'b1) >= width_eff) || !more_after;

	// any issuable entry above the scan pointer
	always_comb begin
		more_after = 1'b0;
		for (int j = 0; j < QUEUE_DEPTH; j++) begin
			if (c_ra[j] && c_rb[j] && !(c_mem[j] && c_seq[j] > lim_q)
				&& (QC_W'(j) < count_q) && (QI_W'(j) > ptr_idx)) begin
				more_after = 1'b1;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		ctl.wake  = (state_q == ST_RD) && (mode_q == MODE_COMPLETE) && wr_q;
		ctl.load  = (state_q == ST_DISP);
		ctl.shift = (state_q == ST_PACK);
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam int NB = (i + 1 < QUEUE_DEPTH) ? i + 1 : i;
		iqws_cell #(.TAG_BITS(TAG_BITS), .XLEN(XLEN)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.sel_load   (count_q == QC_W'(i)),
			.sel_shift  (QI_W'(i) >= gap_q),
			.wake_tag   (seq_q),
			.wake_value (dval_q),
			.in_seq     (seq_q),
			.in_tag_a   (tag1_q),
			.in_rdy_a   (rdy1_q || bhit1_q),
			.in_val_a   (rdy1_q ? val1_q : bres1_q),
			.in_tag_b   (tag2_q),
			.in_rdy_b   (rdy2_q || bhit2_q),
			.in_val_b   (rdy2_q ? val2_q : bres2_q),
			.in_mem     (mem_in_q),
			.nb_seq     (c_seq[NB]),
			.nb_tag_a   (c_ta[NB]),
			.nb_rdy_a   (c_ra[NB]),
			.nb_val_a   (c_va[NB]),
			.nb_tag_b   (c_tb[NB]),
			.nb_rdy_b   (c_rb[NB]),
			.nb_val_b   (c_vb[NB]),
			.nb_mem     (c_mem[NB]),
			.seq_q      (c_seq[i]),
			.tag_a_q    (c_ta[i]),
			.rdy_a_q    (c_ra[i]),
			.val_a_q    (c_va[i]),
			.tag_b_q    (c_tb[i]),
			.rdy_b_q    (c_rb[i]),
			.val_b_q    (c_vb[i]),
			.mem_q      (c_mem[i])
		);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q   <= mode;
			seq_q    <= seq;
			tag1_q   <= src1_tag;
			tag2_q   <= src2_tag;
			rdy1_q   <= src1_ready;
			rdy2_q   <= src2_ready;
			val1_q   <= src1_value;
			val2_q   <= src2_value;
			mem_in_q <= is_memory;
			wr_q     <= writes_dest;
			dval_q   <= done_value;
			lim_q    <= mem_limit;
		end
		if (state_q == ST_RD && mode_q == MODE_COMPLETE && wr_q) begin
			bres_mem[seq_q] <= dval_q;
		end
		bres1_q <= bres_mem[tag1_q];
		bres2_q <= bres_mem[tag2_q];
		if (state_q == ST_SCAN && !scan_end && cand_ok) begin
			out_seq  <= c_seq[ptr_idx];
			out_src1 <= c_va[ptr_idx];
			out_src2 <= c_vb[ptr_idx];
		end else if (state_q != ST_OUT && state_q != ST_PACK) begin
			out_seq  <= '0;
			out_src1 <= '0;
			out_src2 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			width_cfg_q   <= IW_W'(4);
			queue_limit_q <= QL_W'(16);
			bvalid_q      <= '0;
			count_q       <= '0;
			ptr_q         <= '0;
			nissue_q      <= '0;
			gap_q         <= '0;
			bhit1_q       <= 1'b0;
			bhit2_q       <= 1'b0;
			out_valid     <= 1'b0;
			kind          <= KIND_ACCEPTED;
			last          <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ISSUE_WIDTH) begin
					width_cfg_q <= cfg_data[IW_W-1:0];
				end else if (cfg_index == REG_QUEUE_LIMIT) begin
					queue_limit_q <= cfg_data;
				end
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					bvalid_q <= '0;
					state_q  <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					bhit1_q <= bvalid_q[tag1_q];
					bhit2_q <= bvalid_q[tag2_q];
					case (mode_q)
						MODE_DISPATCH: begin
							if (count_q >= limit_eff) begin
								kind    <= KIND_FULL;
								last    <= 1'b1;
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_DISP;
							end
						end
						MODE_COMPLETE: begin
							bvalid_q[seq_q] <= wr_q;
							kind    <= KIND_DONE;
							last    <= 1'b1;
							state_q <= ST_OUT;
						end
						MODE_ISSUE: begin
							ptr_q    <= '0;
							nissue_q <= '0;
							state_q  <= ST_SCAN;
						end
						default: begin
							count_q  <= '0;
							bvalid_q <= '0;
							kind     <= KIND_FLUSHED;
							last     <= 1'b1;
							state_q  <= ST_OUT;
						end
					endcase
				end
				ST_DISP: begin
					count_q <= count_q + 1'b1;
					kind    <= KIND_ACCEPTED;
					last    <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_SCAN: begin
					if (scan_end) begin
						if (nissue_q == '0) begin
							kind    <= KIND_NONE;
							last    <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (cand_ok) begin
						gap_q   <= ptr_idx;
						kind    <= KIND_ISSUED;
						last    <= last_issue;
						state_q <= ST_PACK;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_PACK: begin
					count_q   <= count_q - 1'b1;
					nissue_q  <= nissue_q + 1'b1;
					state_q   <= ST_OUT;
				end
				default: begin
					// hold the result until it transfers
					if (!out_valid) begin
						out_valid <= 1'b1;
					end else if (!out_stall) begin
						if (kind == KIND_ISSUED && !last) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

endmodule
